@@ sv/bive_pkg.sv @@
// Shared types and constants for the BER integer varbind encoder.
// No dependencies; used by bive_cell and ber_integer_varbind_encoder.
package bive_pkg;

  localparam int unsigned MAX_PREFIX_BYTES = 8;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER  = 8'h02;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 2'd1;

  typedef struct packed {
    logic [63:0] pre_bytes;
    logic [3:0]  pre_len;
    logic [7:0]  suffix;
    logic [63:0] value;
    logic [3:0]  size;
  } frame_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } cell_t;

endpackage

@@ sv/bive_cell.sv @@
// One byte slot of the output shift chain: loads its byte of a new binding
// or takes the byte of its upstream neighbor. Depends on bive_pkg.
module bive_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_en_i,
  input  bive_pkg::frame_t frame_i,
  input  bive_pkg::cell_t  next_i,
  output bive_pkg::cell_t  cell_o
);

  localparam logic [4:0] K = 5'(IDX);

  logic [4:0]  sfx_pos;
  logic [4:0]  total;
  logic [4:0]  vend;
  logic [4:0]  pos;
  logic [4:0]  vidx;
  logic [63:0] pshift;
  logic [63:0] vshift;
  logic [7:0]  len_byte;
  bive_pkg::cell_t load_d;
  bive_pkg::cell_t cell_d;
  logic       valid_q;
  logic       last_q;
  logic [7:0] data_q;

  assign sfx_pos  = 5'(frame_i.pre_len) + 5'd2;
  assign total    = 5'(frame_i.pre_len) + 5'd5 + 5'(frame_i.size);
  assign vend     = sfx_pos + 5'd3 + 5'(frame_i.size);
  assign pos      = K - 5'd2;
  assign vidx     = vend - 5'd1 - K;
  assign pshift   = frame_i.pre_bytes << {pos, 3'b000};
  assign vshift   = frame_i.value >> {vidx, 3'b000};
  assign len_byte = 8'(frame_i.pre_len) + 8'd3 + 8'(frame_i.size);

  always_comb begin
    load_d.valid = (K < total);
    load_d.last  = (K == total - 5'd1);
    if (K == 5'd0) begin
      load_d.data = bive_pkg::TAG_SEQUENCE;
    end else if (K == 5'd1) begin
      load_d.data = len_byte;
    end else if (K < sfx_pos) begin
      load_d.data = pshift[63:56];
    end else if (K == sfx_pos) begin
      load_d.data = frame_i.suffix;
    end else if (K == sfx_pos + 5'd1) begin
      load_d.data = bive_pkg::TAG_INTEGER;
    end else if (K == sfx_pos + 5'd2) begin
      load_d.data = 8'(frame_i.size);
    end else begin
      load_d.data = vshift[7:0];
    end
    cell_d = load_en_i ? load_d : next_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= cell_d.last;
    data_q <= cell_d.data;
  end

  assign cell_o = '{valid: valid_q, last: last_q, data: data_q};

endmodule

@@ sv/ber_integer_varbind_encoder.sv @@
// Top level of the BER integer varbind encoder: config registers and the
// byte shift chain built from bive_cell. Depends on bive_pkg and bive_cell.
//
// A request (start_i while busy_o is low) is laid out at once across a chain
// of byte cells and shifted out one byte per cycle on out_byte_o, marked by
// out_strobe_o, with last_o on the final byte. The first byte appears the
// cycle after the request. A binding is the prefix count (prefix_length
// capped at MAX_PREFIX_BYTES) + 5 + size bytes long, 6 to 21. busy_o drops
// while the final byte of a binding is on the port, so the next request can
// follow with no gap. The receiver cannot stall: each byte is present for
// exactly one cycle. The user must write configuration only while idle; the
// block itself does not enforce it.
module ber_integer_varbind_encoder #(
  parameter int unsigned MAX_PREFIX_BYTES = bive_pkg::MAX_PREFIX_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bive_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                    cfg_data_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [7:0]                     oid_suffix_i,
  input  logic [63:0]                    value_i,
  input  logic [1:0]                     value_size_i,
  output logic                           out_strobe_o,
  output logic [7:0]                     out_byte_o,
  output logic                           last_o
);

  localparam int unsigned DEPTH = MAX_PREFIX_BYTES + 13;
  localparam logic [3:0] MAX_PRE = 4'(MAX_PREFIX_BYTES);

  logic [63:0] prefix_q;
  logic [3:0]  plen_q;
  logic        load_en;
  bive_pkg::frame_t frame;
  bive_pkg::cell_t  chain [DEPTH+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      plen_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bive_pkg::REG_PREFIX_BYTES) begin
        prefix_q <= cfg_data_i;
      end
      if (cfg_idx_i == bive_pkg::REG_PREFIX_LENGTH) begin
        plen_q <= cfg_data_i[3:0];
      end
    end
  end

  assign load_en = start_i && !busy_o;

  always_comb begin
    frame.pre_bytes = prefix_q;
    frame.pre_len   = (plen_q > MAX_PRE) ? MAX_PRE : plen_q;
    frame.suffix    = oid_suffix_i;
    frame.value     = value_i;
    frame.size      = 4'd1 << value_size_i;
  end

  assign chain[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bive_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_en_i(load_en),
      .frame_i  (frame),
      .next_i   (chain[g+1]),
      .cell_o   (chain[g])
    );
  end

  assign busy_o       = chain[1].valid;
  assign out_strobe_o = chain[0].valid;
  assign out_byte_o   = chain[0].data;
  assign last_o       = chain[0].last;

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> out_strobe_o && out_byte_o == bive_pkg::TAG_SEQUENCE)
    else $error("request not followed by sequence tag");

  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> out_strobe_o && !last_o)
    else $error("busy without a non-final byte on the port");

  a_end_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_o && !start_i |=> !out_strobe_o)
    else $error("byte emitted after final byte with no request");

endmodule
